[rtl/flip_controlled_interval_timer_defines.svh]
// Assertion macros shared by the interval timer RTL.
// Depends on nothing; the including module must have aclk and aresetn in scope.
`ifndef FLIP_CONTROLLED_INTERVAL_TIMER_DEFINES_SVH
`define FLIP_CONTROLLED_INTERVAL_TIMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FCIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FCIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fcit_pkg.sv]
// Types, codes and widths for the interval timer.
// No dependencies; imported by every module of the block.
package fcit_pkg;

    localparam int unsigned LEN_W   = 24;  // phase lengths in ms (255 min max)
    localparam int unsigned TIME_W  = 32;  // free-running ms timestamp
    localparam int unsigned QUOT_W  = 10;  // per-mille result, 0..1000
    localparam int unsigned PROD_W  = LEN_W + QUOT_W;
    localparam int unsigned DSH_W   = LEN_W + QUOT_W - 1;
    localparam int unsigned CNT_W   = $clog2(QUOT_W);
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [15:0]       MS_PER_MINUTE = 16'd60000;
    localparam logic [QUOT_W-1:0] PERMILLE_FULL = 10'd1000;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_FOCUS_MIN = 2'd0;
    localparam logic [1:0] REG_BREAK_MIN = 2'd1;
    localparam logic [1:0] REG_ROUNDS    = 2'd2;

    // request kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_BEGIN   = 2'd1;
    localparam logic [1:0] KIND_STOP    = 2'd2;
    localparam logic [1:0] KIND_CONSUME = 2'd3;

    // orientation codes
    localparam logic [2:0] OR_UNKNOWN = 3'd0;
    localparam logic [2:0] OR_FLAT    = 3'd1;
    localparam logic [2:0] OR_SIDE_A  = 3'd2;
    localparam logic [2:0] OR_SIDE_B  = 3'd3;

    typedef enum logic [2:0] {
        PH_WAIT_FOCUS   = 3'd0,
        PH_FOCUS        = 3'd1,
        PH_PAUSED_FOCUS = 3'd2,
        PH_WAIT_BREAK   = 3'd3,
        PH_BREAK        = 3'd4,
        PH_PAUSED_BREAK = 3'd5,
        PH_COMPLETE     = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TIME_W-1:0] now_ms;
        logic [2:0]        orientation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic [7:0]        round_now;
        logic [LEN_W-1:0]  remaining_ms;
        logic [QUOT_W-1:0] progress_permille;
        logic              cue;
    } out_item_t;

    typedef struct packed {
        logic [7:0] focus_minutes;
        logic [7:0] break_minutes;
        logic [7:0] round_count;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic do_step;
        logic do_left;
        logic do_mul;
        logic div_start;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/fcit_div.sv]
// Restoring divider for the per-mille figure, one quotient bit per cycle.
// Depends on fcit_pkg; quotient is known to stay below 2**QUOT_W.
module fcit_div import fcit_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [LEN_W-1:0]  divisor,
    output logic [QUOT_W-1:0] quotient,
    output logic              done
);

    logic [PROD_W-1:0] rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    assign fits = rem_reg >= PROD_W'(dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            dsh_reg  <= {divisor, {(QUOT_W - 1){1'b0}}};
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - PROD_W'(dsh_reg);
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

[rtl/fcit_dp.sv]
// Datapath of the interval timer: session state, time arithmetic, result register.
// Depends on fcit_pkg and fcit_div; sequenced by fcit_ctrl through ctrl_cmd_t.
module fcit_dp import fcit_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  cfg_t       cfg,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    function automatic logic [2:0] opposite_side(input logic [2:0] o);
        logic [2:0] r;
        r = OR_UNKNOWN;
        if (o == OR_SIDE_A) r = OR_SIDE_B;
        if (o == OR_SIDE_B) r = OR_SIDE_A;
        return r;
    endfunction

    in_item_t          in_reg;
    phase_t            phase_reg, phase_next;
    logic [7:0]        round_reg, round_next;
    logic [2:0]        active_reg, active_next;
    logic [2:0]        target_reg, target_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [LEN_W-1:0]  paused_reg, paused_next;
    logic [LEN_W-1:0]  focus_len_reg, focus_len_next;
    logic [LEN_W-1:0]  break_len_reg, break_len_next;
    logic              held_reg, held_next;
    logic              cue_reg, cue_next;
    logic              cue_out_reg, cue_out_next;

    logic [LEN_W-1:0]  left_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [LEN_W-1:0]  divisor_reg;
    logic              force_reg;
    logic [QUOT_W-1:0] force_val_reg;
    out_item_t         out_reg;
    logic              m_valid_reg;

    logic [TIME_W-1:0] elapsed;
    logic              running;
    logic              paused;
    logic              expired;
    logic [LEN_W-1:0]  left_run;
    logic [LEN_W-1:0]  left_val;
    logic              o_short;
    logic              held_eff;
    logic [2:0]        opp;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  rem_clip;
    logic [QUOT_W-1:0] quotient;
    logic              div_done;

    // time left in the current phase, from the registered state
    assign running  = (phase_reg == PH_FOCUS) || (phase_reg == PH_BREAK);
    assign paused   = (phase_reg == PH_PAUSED_FOCUS) || (phase_reg == PH_PAUSED_BREAK);
    assign elapsed  = in_reg.now_ms - start_reg;
    assign expired  = running && (elapsed >= TIME_W'(plen_reg));
    assign left_run = plen_reg - elapsed[LEN_W-1:0];
    assign left_val = paused ? paused_reg : ((running && !expired) ? left_run : '0);
    assign o_short  = (in_reg.orientation == OR_SIDE_A) || (in_reg.orientation == OR_SIDE_B);
    assign opp      = opposite_side(active_reg);

    always_comb begin
        phase_next     = phase_reg;
        round_next     = round_reg;
        active_next    = active_reg;
        target_next    = target_reg;
        start_next     = start_reg;
        plen_next      = plen_reg;
        paused_next    = paused_reg;
        focus_len_next = focus_len_reg;
        break_len_next = break_len_reg;
        held_next      = held_reg;
        cue_next       = cue_reg;
        cue_out_next   = cue_out_reg;
        held_eff       = 1'b0;
        if (cmd.do_step) begin
            case (in_reg.kind)
                KIND_TICK: begin
                    cue_out_next = cue_reg;
                    if (expired) begin
                        cue_next     = 1'b1;
                        cue_out_next = 1'b1;
                        if (phase_reg == PH_FOCUS && round_reg >= cfg.round_count) begin
                            phase_next = PH_COMPLETE;
                            plen_next  = '0;
                        end else begin
                            if (phase_reg == PH_BREAK) begin
                                round_next = round_reg + 8'd1;
                            end
                            phase_next  = (phase_reg == PH_FOCUS) ? PH_WAIT_BREAK
                                                                  : PH_WAIT_FOCUS;
                            target_next = opp;
                            held_next   = (in_reg.orientation == opp);
                            plen_next   = '0;
                            paused_next = '0;
                        end
                    end else begin
                        case (phase_reg)
                            PH_WAIT_FOCUS, PH_WAIT_BREAK: begin
                                held_eff  = held_reg && o_short &&
                                            (in_reg.orientation == target_reg);
                                held_next = held_eff;
                                if (o_short && !held_eff &&
                                    (target_reg == OR_UNKNOWN ||
                                     in_reg.orientation == target_reg)) begin
                                    phase_next  = (phase_reg == PH_WAIT_FOCUS) ? PH_FOCUS
                                                                               : PH_BREAK;
                                    plen_next   = (phase_reg == PH_WAIT_FOCUS) ? focus_len_reg
                                                                               : break_len_reg;
                                    active_next = in_reg.orientation;
                                    start_next  = in_reg.now_ms;
                                    paused_next = '0;
                                    target_next = OR_UNKNOWN;
                                    held_next   = 1'b0;
                                end
                            end
                            PH_FOCUS, PH_BREAK: begin
                                if (in_reg.orientation == OR_FLAT) begin
                                    paused_next = left_run;
                                    phase_next  = (phase_reg == PH_FOCUS) ? PH_PAUSED_FOCUS
                                                                          : PH_PAUSED_BREAK;
                                end
                            end
                            PH_PAUSED_FOCUS, PH_PAUSED_BREAK: begin
                                if (in_reg.orientation == active_reg) begin
                                    plen_next  = paused_reg;
                                    start_next = in_reg.now_ms;
                                    phase_next = (phase_reg == PH_PAUSED_FOCUS) ? PH_FOCUS
                                                                                : PH_BREAK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                KIND_BEGIN: begin
                    focus_len_next = LEN_W'(cfg.focus_minutes) * LEN_W'(MS_PER_MINUTE);
                    break_len_next = LEN_W'(cfg.break_minutes) * LEN_W'(MS_PER_MINUTE);
                    round_next     = 8'd1;
                    phase_next     = PH_WAIT_FOCUS;
                    active_next    = OR_UNKNOWN;
                    target_next    = OR_UNKNOWN;
                    start_next     = '0;
                    plen_next      = '0;
                    paused_next    = '0;
                    held_next      = 1'b0;
                    cue_next       = 1'b0;
                    cue_out_next   = 1'b0;
                end
                KIND_STOP: begin
                    phase_next   = PH_COMPLETE;
                    cue_next     = 1'b0;
                    cue_out_next = 1'b0;
                end
                KIND_CONSUME: begin
                    cue_out_next = cue_reg;
                    cue_next     = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_COMPLETE;
            round_reg     <= '0;
            active_reg    <= OR_UNKNOWN;
            target_reg    <= OR_UNKNOWN;
            start_reg     <= '0;
            plen_reg      <= '0;
            paused_reg    <= '0;
            focus_len_reg <= '0;
            break_len_reg <= '0;
            held_reg      <= 1'b0;
            cue_reg       <= 1'b0;
            cue_out_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            active_reg    <= active_next;
            target_reg    <= target_next;
            start_reg     <= start_next;
            plen_reg      <= plen_next;
            paused_reg    <= paused_next;
            focus_len_reg <= focus_len_next;
            break_len_reg <= break_len_next;
            held_reg      <= held_next;
            cue_reg       <= cue_next;
            cue_out_reg   <= cue_out_next;
        end
    end

    // phase total for the per-mille figure; zero outside focus and break
    always_comb begin
        case (phase_reg)
            PH_FOCUS, PH_PAUSED_FOCUS: total = focus_len_reg;
            PH_BREAK, PH_PAUSED_BREAK: total = break_len_reg;
            default:                   total = '0;
        endcase
    end

    assign rem_clip = (left_reg > total) ? total : left_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.do_left) begin
            left_reg <= left_val;
        end
        if (cmd.do_mul) begin
            prod_reg      <= PROD_W'(total - rem_clip) * PROD_W'(PERMILLE_FULL);
            divisor_reg   <= total;
            force_reg     <= (total == '0);
            force_val_reg <= (phase_reg == PH_WAIT_BREAK || phase_reg == PH_COMPLETE)
                             ? PERMILLE_FULL : '0;
        end
        if (cmd.load_out) begin
            out_reg.phase             <= phase_reg;
            out_reg.round_now         <= round_reg;
            out_reg.remaining_ms      <= left_reg;
            out_reg.progress_permille <= force_reg ? force_val_reg : quotient;
            out_reg.cue               <= cue_out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    fcit_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

endmodule

[rtl/fcit_ctrl.sv]
// Sequencer of the interval timer: walks one request through the datapath.
// Depends on fcit_pkg; drives fcit_dp through ctrl_cmd_t.
module fcit_ctrl import fcit_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_STEP   = 7'b0000010,
        ST_LEFT   = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DSTART = 7'b0010000,
        ST_DWAIT  = 7'b0100000,
        ST_PUSH   = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_STEP;
            ST_STEP:   state_next = ST_LEFT;
            ST_LEFT:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:  if (status.div_done) state_next = ST_PUSH;
            ST_PUSH:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // hold off requests while reset is applied
    assign s_ready       = aresetn && (state_reg == ST_IDLE);
    assign cmd.load_in   = (state_reg == ST_IDLE) && s_valid;
    assign cmd.do_step   = (state_reg == ST_STEP);
    assign cmd.do_left   = (state_reg == ST_LEFT);
    assign cmd.do_mul    = (state_reg == ST_MUL);
    assign cmd.div_start = (state_reg == ST_DSTART);
    assign cmd.load_out  = (state_reg == ST_PUSH) && status.out_free;

endmodule

[rtl/flip_controlled_interval_timer.sv]
// Flip-controlled work/break interval timer, top level.
// Depends on fcit_pkg, fcit_ctrl, fcit_dp and the assertion macro header.
//
// Usage:
//   s_ channel takes one request (kind, now_ms, orientation) per handshake;
//   m_ channel returns exactly one status result (phase, round, remaining
//   time, per-mille progress, cue) for every request, in order.
//   The APB port sets focus/break minutes and round count at 0x0/0x4/0x8;
//   write them only while no request is in flight. Lengths are latched by a
//   begin request, the round count is read live.
// Timing:
//   A request is handled one at a time: step, remaining-time, multiply, then
//   a restoring divider that yields one per-mille bit per cycle (10 bits).
//   The result lands in the output register once the receiver is free and
//   s_ready returns the cycle after, so no new request is taken until the
//   last result is loaded. The divider takes most of the time per request.
// Reset (aresetn low, synchronous): phase complete, round 0, cue clear,
//   registers back to 25/5/4 minutes/rounds, no result pending.
// Stall: a held result waits in the output register; the next request is
//   still accepted and computed, and waits before loading until m_ready.
`include "flip_controlled_interval_timer_defines.svh"

module flip_controlled_interval_timer import fcit_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       cfg_write;

    // Register write on the access phase; unmapped addresses drop the write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focus_minutes <= 8'd25;
            cfg_reg.break_minutes <= 8'd5;
            cfg_reg.round_count   <= 8'd4;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_FOCUS_MIN: cfg_reg.focus_minutes <= pwdata[7:0];
                REG_BREAK_MIN: cfg_reg.break_minutes <= pwdata[7:0];
                REG_ROUNDS:    cfg_reg.round_count   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero for unmapped addresses.
    always_comb begin
        case (paddr[3:2])
            REG_FOCUS_MIN: prdata = DATA_W'(cfg_reg.focus_minutes);
            REG_BREAK_MIN: prdata = DATA_W'(cfg_reg.break_minutes);
            REG_ROUNDS:    prdata = DATA_W'(cfg_reg.round_count);
            default:       prdata = '0;
        endcase
    end

    // Sequencer: one request at a time, advance on divider done, hold on stall.
    fcit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Session state, arithmetic and the output register.
    fcit_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `FCIT_ASSERT_NEXT(a_one_request_in_flight, s_valid && s_ready, !s_ready,
        "request accepted while another is being handled")

    `FCIT_ASSERT_NOW(a_progress_in_range, m_valid,
        m_data.progress_permille <= PERMILLE_FULL,
        "per-mille progress above 1000")

    `FCIT_ASSERT_NOW(a_idle_phase_no_time,
        m_valid && (m_data.phase == PH_WAIT_FOCUS || m_data.phase == PH_WAIT_BREAK ||
                    m_data.phase == PH_COMPLETE),
        m_data.remaining_ms == '0,
        "remaining time reported outside a running or paused phase")

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for the flip-controlled interval timer: a status predictor
// and result scoreboard, request and APB drivers, and directed then random requests.
// Depends on fcit_pkg and the flip_controlled_interval_timer RTL.
module tb_top;
    import fcit_pkg::*;

    // Status predictor plus the store of expected status results, oldest first.
    class interval_scoreboard;
        bit [7:0]  focus_min;
        bit [7:0]  break_min;
        bit [7:0]  rounds_max;
        phase_t    phase;
        bit [7:0]  round_no;
        bit [2:0]  active_side;
        bit [2:0]  wait_side;
        bit [31:0] start_ms;
        bit [31:0] run_len;
        bit [31:0] paused_ms;
        bit [31:0] focus_len;
        bit [31:0] break_len;
        bit        held_at_wait;
        bit        cue_pend;
        out_item_t expected_q[$];
        int unsigned mismatches;

        function new();
            focus_min    = 8'd25;
            break_min    = 8'd5;
            rounds_max   = 8'd4;
            phase        = PH_COMPLETE;
            round_no     = '0;
            active_side  = OR_UNKNOWN;
            wait_side    = OR_UNKNOWN;
            start_ms     = '0;
            run_len      = '0;
            paused_ms    = '0;
            focus_len    = '0;
            break_len    = '0;
            held_at_wait = 1'b0;
            cue_pend     = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_FOCUS_MIN: focus_min  = val;
                REG_BREAK_MIN: break_min  = val;
                REG_ROUNDS:    rounds_max = val;
                default: ;
            endcase
        endfunction

        function bit [31:0] left_at(bit [31:0] now_ms);
            bit [31:0] el;
            if (phase == PH_PAUSED_FOCUS || phase == PH_PAUSED_BREAK)
                return paused_ms;
            if (phase != PH_FOCUS && phase != PH_BREAK)
                return '0;
            el = now_ms - start_ms;
            return (el >= run_len) ? 32'd0 : run_len - el;
        endfunction

        function void note_request(in_item_t req);
            bit [31:0]       t;
            bit [2:0]        o;
            bit              cue_out;
            bit [31:0]       rem;
            bit [31:0]       clipped;
            bit [31:0]       total;
            longint unsigned pm;
            out_item_t       want;
            t = req.now_ms;
            o = req.orientation;
            case (req.kind)
                KIND_TICK: begin
                    if ((phase == PH_FOCUS || phase == PH_BREAK) && t - start_ms >= run_len) begin
                        // expiry: nothing else happens on this tick
                        if (phase == PH_FOCUS && round_no >= rounds_max) begin
                            phase   = PH_COMPLETE;
                            run_len = '0;
                        end else begin
                            if (phase == PH_BREAK)
                                round_no = round_no + 8'd1;
                            phase = (phase == PH_FOCUS) ? PH_WAIT_BREAK : PH_WAIT_FOCUS;
                            if (active_side == OR_SIDE_A)
                                wait_side = OR_SIDE_B;
                            else if (active_side == OR_SIDE_B)
                                wait_side = OR_SIDE_A;
                            else
                                wait_side = OR_UNKNOWN;
                            held_at_wait = (o == wait_side);
                            run_len      = '0;
                            paused_ms    = '0;
                        end
                        cue_pend = 1'b1;
                    end else begin
                        case (phase)
                            PH_WAIT_FOCUS, PH_WAIT_BREAK: begin
                                if (!(o == OR_SIDE_A || o == OR_SIDE_B) || o != wait_side)
                                    held_at_wait = 1'b0;
                                if ((o == OR_SIDE_A || o == OR_SIDE_B) &&
                                    (wait_side == OR_UNKNOWN || o == wait_side) &&
                                    !held_at_wait) begin
                                    phase        = (phase == PH_WAIT_FOCUS) ? PH_FOCUS : PH_BREAK;
                                    active_side  = o;
                                    start_ms     = t;
                                    run_len      = (phase == PH_FOCUS) ? focus_len : break_len;
                                    paused_ms    = '0;
                                    wait_side    = OR_UNKNOWN;
                                    held_at_wait = 1'b0;
                                end
                            end
                            PH_FOCUS, PH_BREAK: begin
                                if (o == OR_FLAT) begin
                                    paused_ms = left_at(t);
                                    phase = (phase == PH_FOCUS) ? PH_PAUSED_FOCUS : PH_PAUSED_BREAK;
                                end
                            end
                            PH_PAUSED_FOCUS, PH_PAUSED_BREAK: begin
                                if (o == active_side) begin
                                    run_len  = paused_ms;
                                    start_ms = t;
                                    phase = (phase == PH_PAUSED_FOCUS) ? PH_FOCUS : PH_BREAK;
                                end
                            end
                            default: ;
                        endcase
                    end
                    cue_out = cue_pend;
                end
                KIND_BEGIN: begin
                    focus_len    = 32'(focus_min) * 32'(MS_PER_MINUTE);
                    break_len    = 32'(break_min) * 32'(MS_PER_MINUTE);
                    round_no     = 8'd1;
                    phase        = PH_WAIT_FOCUS;
                    active_side  = OR_UNKNOWN;
                    wait_side    = OR_UNKNOWN;
                    start_ms     = '0;
                    run_len      = '0;
                    paused_ms    = '0;
                    held_at_wait = 1'b0;
                    cue_pend     = 1'b0;
                    cue_out      = cue_pend;
                end
                KIND_STOP: begin
                    phase    = PH_COMPLETE;
                    cue_pend = 1'b0;
                    cue_out  = 1'b0;
                end
                default: begin
                    cue_out  = cue_pend;
                    cue_pend = 1'b0;
                end
            endcase

            rem = left_at(t);
            // progress is measured against the full latched length, even after a resume
            if (phase == PH_WAIT_BREAK)
                pm = 1000;
            else if (phase == PH_WAIT_FOCUS)
                pm = 0;
            else begin
                if (phase == PH_FOCUS || phase == PH_PAUSED_FOCUS)
                    total = focus_len;
                else if (phase == PH_BREAK || phase == PH_PAUSED_BREAK)
                    total = break_len;
                else
                    total = '0;
                if (total == 0)
                    pm = (phase == PH_COMPLETE) ? 1000 : 0;
                else begin
                    clipped = (rem > total) ? total : rem;
                    pm = (64'(total - clipped) * 64'd1000) / 64'(total);
                end
            end

            want.phase             = phase;
            want.round_now         = round_no;
            want.remaining_ms      = rem[23:0];
            want.progress_permille = pm[9:0];
            want.cue               = cue_out;
            expected_q.push_back(want);
        endfunction

        function void flag(string what, out_item_t want, out_item_t got);
            string want_s;
            string got_s;
            mismatches++;
            if (mismatches <= 10) begin
                want_s = $sformatf("ph %0d rnd %0d left %0d pm %0d cue %0d", want.phase,
                                   want.round_now, want.remaining_ms,
                                   want.progress_permille, want.cue);
                got_s  = $sformatf("ph %0d rnd %0d left %0d pm %0d cue %0d", got.phase,
                                   got.round_now, got.remaining_ms,
                                   got.progress_permille, got.cue);
                $display("%s: expected %s, got %s", what, want_s, got_s);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0) begin
                flag("status result with none expected", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.phase !== want.phase || got.round_now !== want.round_now ||
                got.remaining_ms !== want.remaining_ms ||
                got.progress_permille !== want.progress_permille || got.cue !== want.cue)
                flag("status field differs", want, got);
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    interval_scoreboard sb = new();

    // idling odds in percent, changed only between phases
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    // running millisecond time stamp carried by random requests
    logic [31:0] stim_ms = '0;

    flip_controlled_interval_timer DUT (.*);

    always #1 aclk = ~aclk;

    // Stall the result channel at random; one assignment per edge.
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Check every status result the moment it is handed over.
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);

    // Hold off a random while, then present one request and hold it until accepted.
    // Valid is only dropped when an idle gap is taken, so it never toggles within a step.
    task automatic send_request(input logic [1:0] kind, input logic [31:0] t,
                                input logic [2:0] o);
        in_item_t req;
        req.kind        = kind;
        req.now_ms      = t;
        req.orientation = o;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req);
    endtask

    // Drop valid and wait until every expected status has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where the access phase meets pready.
    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, val);
    endtask

    // Random requests steered by the predicted state: mostly the orientation that
    // moves the session forward, with pauses, wrong sides and noise mixed in.
    task automatic run_random(input int unsigned count);
        int unsigned pick;
        logic [1:0]  kind;
        logic [2:0]  o;
        for (int unsigned n = 0; n < count; n++) begin
            // advance time: small steps, right at expiry, big jumps, anywhere, or not at all
            pick = $urandom_range(0, 15);
            if (pick <= 5)
                stim_ms = stim_ms + $urandom_range(0, 3000);
            else if (pick <= 8)
                stim_ms = sb.start_ms + sb.run_len - 32'd1 + $urandom_range(0, 3);
            else if (pick <= 10)
                stim_ms = stim_ms + $urandom_range(0, 20_000_000);
            else if (pick == 11)
                stim_ms = $urandom;

            pick = $urandom_range(0, 99);
            if (sb.phase == PH_COMPLETE)
                kind = (pick < 50) ? KIND_BEGIN : (pick < 70) ? KIND_CONSUME :
                       (pick < 75) ? KIND_STOP : KIND_TICK;
            else
                kind = (pick < 3) ? KIND_BEGIN : (pick < 5) ? KIND_STOP :
                       (pick < 12) ? KIND_CONSUME : KIND_TICK;

            // side A and side B differ only in bit 0, so xor 1 gives the opposite side
            pick = $urandom_range(0, 99);
            if (pick < 15)
                o = 3'($urandom_range(0, 7));
            else begin
                case (sb.phase)
                    PH_WAIT_FOCUS, PH_WAIT_BREAK: begin
                        if (sb.wait_side == OR_UNKNOWN)
                            o = pick[0] ? OR_SIDE_A : OR_SIDE_B;
                        else if (pick < 70)
                            o = sb.wait_side;
                        else if (pick < 85)
                            o = OR_FLAT;
                        else
                            o = sb.wait_side ^ 3'd1;
                    end
                    PH_FOCUS, PH_BREAK:
                        o = (pick < 30) ? OR_FLAT : (pick < 45) ? (sb.active_side ^ 3'd1) :
                            sb.active_side;
                    PH_PAUSED_FOCUS, PH_PAUSED_BREAK:
                        o = (pick < 60) ? sb.active_side : OR_FLAT;
                    default:
                        o = 3'($urandom_range(0, 7));
                endcase
            end
            send_request(kind, stim_ms, o);
        end
    endtask

    initial begin
        // hold reset, once, at the start
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk under the reset-time register values
        send_request(KIND_TICK,    32'd0,          OR_UNKNOWN);  // update while complete
        send_request(KIND_CONSUME, 32'hFFFF_FFFF,  3'd7);
        send_request(KIND_BEGIN,   32'd100,        OR_FLAT);
        send_request(KIND_TICK,    32'd200,        OR_FLAT);     // flat does not start
        send_request(KIND_TICK,    32'd1000,       OR_SIDE_A);   // either side starts focus
        send_request(KIND_TICK,    32'd500000,     3'd4);        // non-short side ignored
        send_request(KIND_TICK,    32'd600000,     OR_FLAT);     // pause
        send_request(KIND_TICK,    32'd700000,     OR_SIDE_B);   // wrong side, stay paused
        send_request(KIND_TICK,    32'd800000,     OR_SIDE_A);   // resume
        send_request(KIND_TICK,    32'd1701000,    OR_SIDE_A);   // focus expires, cue set
        send_request(KIND_CONSUME, 32'd1701100,    OR_SIDE_A);
        send_request(KIND_TICK,    32'd1701500,    OR_SIDE_B);   // break on opposite side
        send_request(KIND_TICK,    32'd2001500,    OR_SIDE_A);   // expires with target held
        send_request(KIND_TICK,    32'd2001600,    OR_SIDE_A);   // held side must be left first
        send_request(KIND_TICK,    32'd2001700,    3'd5);
        send_request(KIND_TICK,    32'd2001800,    OR_SIDE_A);
        send_request(KIND_STOP,    32'hFFFF_FFFF,  3'd6);
        send_request(KIND_BEGIN,   32'hFFFF_FF00,  OR_SIDE_B);
        send_request(KIND_TICK,    32'hFFFF_FF00,  OR_SIDE_B);
        send_request(KIND_TICK,    32'h0000_0100,  OR_SIDE_B);   // elapsed time wraps
        drain_results();

        // zero lengths and zero rounds: the first focus ends the session
        write_register(REG_FOCUS_MIN, 8'd0);
        write_register(REG_BREAK_MIN, 8'd0);
        write_register(REG_ROUNDS,    8'd0);
        send_request(KIND_BEGIN,   32'd5,          3'd7);
        send_request(KIND_TICK,    32'd6,          OR_SIDE_B);   // zero-length focus, progress 0
        send_request(KIND_TICK,    32'd6,          OR_SIDE_B);   // expires on next update
        send_request(KIND_CONSUME, 32'd7,          OR_FLAT);

        // random phases, each with an idling mix and a register setting
        for (int seg = 0; seg < 6; seg++) begin
            drain_results();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (seg)
                0: begin
                    write_register(REG_FOCUS_MIN, 8'd2);
                    write_register(REG_BREAK_MIN, 8'd1);
                    write_register(REG_ROUNDS,    8'd2);
                end
                1: begin
                    write_register(REG_FOCUS_MIN, 8'd255);
                    write_register(REG_BREAK_MIN, 8'd255);
                    write_register(REG_ROUNDS,    8'd255);
                end
                2: begin
                    write_register(REG_FOCUS_MIN, 8'd0);
                    write_register(REG_BREAK_MIN, 8'd3);
                    write_register(REG_ROUNDS,    8'd1);
                end
                3: begin
                    write_register(REG_FOCUS_MIN, 8'd1);
                    write_register(REG_BREAK_MIN, 8'd0);
                    write_register(REG_ROUNDS,    8'd3);
                end
                default: begin
                    write_register(REG_FOCUS_MIN, 8'($urandom_range(0, 255)));
                    write_register(REG_BREAK_MIN, 8'($urandom_range(0, 255)));
                    write_register(REG_ROUNDS,    8'($urandom_range(0, 6)));
                end
            endcase
            run_random(255);
        end

        // wait out the last results, then a little more to catch strays
        drain_results();
        repeat (40) @(posedge aclk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("flip_controlled_interval_timer: match");
        else
            $display("flip_controlled_interval_timer: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("flip_controlled_interval_timer: mismatch");
        $finish;
    end

endmodule
